>>> hdl/dfa_pkg.sv
// Shared types and constants for the dragonfly node allocator.
// No dependencies; every other file of the block imports this package.
package dfa_pkg;

  localparam int MAP_DEPTH = 64;
  localparam int NODE_W    = 6;
  localparam int SIZE_W    = 7;
  localparam int ROUTER_W  = 4;
  localparam int RIG_W     = 2;
  localparam int GROUP_W   = 2;
  localparam int RCNT_W    = 3;
  localparam int GCNT_W    = 5;
  localparam int LOCAL_W   = 4;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    STAT_GRANT   = 2'd0,
    STAT_REJECT  = 2'd1,
    STAT_RELEASE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SCAN,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic              operation;
    logic [SIZE_W-1:0] job_size;
    logic [NODE_W-1:0] release_node;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] granted_node;
    status_t           status;
    logic              last;
  } out_item_t;

  // Summary of one counting pass over the free map.
  typedef struct packed {
    logic                done;
    logic [SIZE_W-1:0]   total;
    logic [ROUTER_W-1:0] best_router;
    logic [RCNT_W-1:0]   best_router_cnt;
    logic [GROUP_W-1:0]  best_group;
  } cnt_res_t;

endpackage

>>> hdl/dfa_counter.sv
// Iterative free-node counter: one router per cycle through a shared popcount
// and compare unit. Depends on dfa_pkg.
module dfa_counter import dfa_pkg::*; #(
  parameter int NODES_PER_ROUTER  = 4,
  parameter int ROUTERS_PER_GROUP = 4,
  parameter int GROUPS            = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start_i,
  input  logic [MAP_DEPTH-1:0] free_map_i,
  output cnt_res_t             res_o
);

  localparam int TOTAL_ROUTERS = GROUPS * ROUTERS_PER_GROUP;

  logic                active_r, active_nxt;
  logic                done_r, done_nxt;
  logic [ROUTER_W-1:0] rtr_r, rtr_nxt;
  logic [RIG_W-1:0]    rig_r, rig_nxt;
  logic [GROUP_W-1:0]  grp_r, grp_nxt;
  logic [GCNT_W-1:0]   gacc_r, gacc_nxt;
  logic [SIZE_W-1:0]   total_r, total_nxt;
  logic [ROUTER_W-1:0] br_r, br_nxt;
  logic [RCNT_W-1:0]   brc_r, brc_nxt;
  logic [GROUP_W-1:0]  bg_r, bg_nxt;
  logic [GCNT_W-1:0]   bgc_r, bgc_nxt;

  logic [NODE_W-1:0]    base;
  logic [MAP_DEPTH-1:0] window;
  logic [RCNT_W-1:0]    rcnt;
  logic [GCNT_W-1:0]    gsum;

  // Shared unit: popcount of the current router's nodes.
  always_comb begin
    base   = NODE_W'(rtr_r) * NODE_W'(NODES_PER_ROUTER);
    window = free_map_i >> base;
    rcnt   = '0;
    for (int i = 0; i < NODES_PER_ROUTER; i++) begin
      rcnt = rcnt + RCNT_W'(window[i]);
    end
    gsum = gacc_r + GCNT_W'(rcnt);
  end

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    rtr_nxt    = rtr_r;
    rig_nxt    = rig_r;
    grp_nxt    = grp_r;
    gacc_nxt   = gacc_r;
    total_nxt  = total_r;
    br_nxt     = br_r;
    brc_nxt    = brc_r;
    bg_nxt     = bg_r;
    bgc_nxt    = bgc_r;
    if (start_i) begin
      active_nxt = 1'b1;
      rtr_nxt    = '0;
      rig_nxt    = '0;
      grp_nxt    = '0;
      gacc_nxt   = '0;
      total_nxt  = '0;
      br_nxt     = '0;
      brc_nxt    = '0;
      bg_nxt     = '0;
      bgc_nxt    = '0;
    end else if (active_r) begin
      total_nxt = total_r + SIZE_W'(rcnt);
      // Keep the first router with the most free nodes.
      if (rcnt > brc_r) begin
        br_nxt  = rtr_r;
        brc_nxt = rcnt;
      end
      if (rig_r == RIG_W'(ROUTERS_PER_GROUP - 1)) begin
        if (gsum > bgc_r) begin
          bg_nxt  = grp_r;
          bgc_nxt = gsum;
        end
        gacc_nxt = '0;
        rig_nxt  = '0;
        grp_nxt  = grp_r + GROUP_W'(1);
      end else begin
        gacc_nxt = gsum;
        rig_nxt  = rig_r + RIG_W'(1);
      end
      if (rtr_r == ROUTER_W'(TOTAL_ROUTERS - 1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end else begin
        rtr_nxt = rtr_r + ROUTER_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
    end
    rtr_r   <= rtr_nxt;
    rig_r   <= rig_nxt;
    grp_r   <= grp_nxt;
    gacc_r  <= gacc_nxt;
    total_r <= total_nxt;
    br_r    <= br_nxt;
    brc_r   <= brc_nxt;
    bg_r    <= bg_nxt;
    bgc_r   <= bgc_nxt;
  end

  assign res_o.done            = done_r;
  assign res_o.total           = total_r;
  assign res_o.best_router     = br_r;
  assign res_o.best_router_cnt = brc_r;
  assign res_o.best_group      = bg_r;

endmodule

>>> hdl/dfa_out_reg.sv
// Result register: holds one beat until the consumer takes it.
// Depends on dfa_pkg.
module dfa_out_reg import dfa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load_i,
  input  out_item_t data_i,
  output logic      slot_free_o,
  output logic      valid_o,
  input  logic      ready_i,
  output out_item_t data_o
);

  logic      valid_r, valid_nxt;
  out_item_t data_r, data_nxt;

  assign slot_free_o = !valid_r || ready_i;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load_i) begin
      valid_nxt = 1'b1;
      data_nxt  = data_i;
    end else if (ready_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

>>> hdl/dragonfly_node_allocator.sv
// Dragonfly node allocator top: free map, sequencer and node scan.
// Depends on dfa_pkg, dfa_counter and dfa_out_reg.
//
// One item is taken at a time; in_ready is high only while the block is idle.
// A release gives its single result beat through ST_REPLY. An allocate first runs
// a counting pass over all GROUPS*ROUTERS_PER_GROUP routers (one router per cycle
// through the shared popcount and compare unit), then scans the free map one
// node per cycle, emitting at most one grant beat per cycle; a stalled result
// port holds the scan. A rejection answers right after the counting pass.
// The free map is in flip-flops and is all free right out of reset.
module dragonfly_node_allocator import dfa_pkg::*; #(
  parameter int NODES_PER_ROUTER  = 4,
  parameter int ROUTERS_PER_GROUP = 4,
  parameter int GROUPS            = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int NODES_PER_GROUP = ROUTERS_PER_GROUP * NODES_PER_ROUTER;
  localparam int TOTAL_NODES     = GROUPS * NODES_PER_GROUP;

  state_t               state_r, state_nxt;
  logic [MAP_DEPTH-1:0] free_map_r, free_map_nxt;
  logic [SIZE_W-1:0]    size_r, size_nxt;
  logic [SIZE_W-1:0]    k_r, k_nxt;
  logic                 rr_mode_r, rr_mode_nxt;
  logic [NODE_W-1:0]    ptr_r, ptr_nxt;
  logic [GROUP_W-1:0]   rr_g_r, rr_g_nxt;
  logic [LOCAL_W-1:0]   rr_j_r, rr_j_nxt;
  out_item_t            reply_r, reply_nxt;

  logic              cnt_start;
  cnt_res_t          cnt_res;
  logic              slot_free;
  logic              load;
  out_item_t         load_data;
  logic [NODE_W-1:0] scan_node;
  logic              node_free;
  logic              last_take;

  dfa_counter #(
    .NODES_PER_ROUTER  (NODES_PER_ROUTER),
    .ROUTERS_PER_GROUP (ROUTERS_PER_GROUP),
    .GROUPS            (GROUPS)
  ) u_counter (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (cnt_start),
    .free_map_i (free_map_r),
    .res_o      (cnt_res)
  );

  dfa_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (load),
    .data_i      (load_data),
    .slot_free_o (slot_free),
    .valid_o     (out_valid),
    .ready_i     (out_ready),
    .data_o      (out_data)
  );

  always_comb begin
    if (rr_mode_r) begin
      scan_node = NODE_W'(rr_g_r) * NODE_W'(NODES_PER_GROUP) + NODE_W'(rr_j_r);
    end else begin
      scan_node = ptr_r;
    end
    node_free = free_map_r[scan_node];
    last_take = (k_r + SIZE_W'(1)) == size_r;
  end

  always_comb begin
    state_nxt    = state_r;
    free_map_nxt = free_map_r;
    size_nxt     = size_r;
    k_nxt        = k_r;
    rr_mode_nxt  = rr_mode_r;
    ptr_nxt      = ptr_r;
    rr_g_nxt     = rr_g_r;
    rr_j_nxt     = rr_j_r;
    reply_nxt    = reply_r;
    cnt_start    = 1'b0;
    load         = 1'b0;
    load_data    = reply_r;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          size_nxt = in_data.job_size;
          k_nxt    = '0;
          if (in_data.operation == OP_RELEASE) begin
            // Drop releases beyond the machine, but still answer them.
            if (7'(in_data.release_node) < SIZE_W'(TOTAL_NODES)) begin
              free_map_nxt[in_data.release_node] = 1'b1;
            end
            reply_nxt.granted_node = in_data.release_node;
            reply_nxt.status       = STAT_RELEASE;
            reply_nxt.last         = 1'b1;
            state_nxt              = ST_REPLY;
          end else begin
            cnt_start = 1'b1;
            state_nxt = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        if (cnt_res.done) begin
          if (size_r == '0 || size_r > cnt_res.total) begin
            reply_nxt.granted_node = '0;
            reply_nxt.status       = STAT_REJECT;
            reply_nxt.last         = 1'b1;
            state_nxt              = ST_REPLY;
          end else begin
            state_nxt = ST_SCAN;
            rr_g_nxt  = '0;
            rr_j_nxt  = '0;
            if (size_r <= SIZE_W'(NODES_PER_ROUTER) &&
                size_r <= SIZE_W'(cnt_res.best_router_cnt)) begin
              rr_mode_nxt = 1'b0;
              ptr_nxt = NODE_W'(cnt_res.best_router) * NODE_W'(NODES_PER_ROUTER);
            end else if (size_r <= SIZE_W'(2 * NODES_PER_GROUP)) begin
              rr_mode_nxt = 1'b0;
              ptr_nxt = NODE_W'(cnt_res.best_group) * NODE_W'(NODES_PER_GROUP);
            end else begin
              rr_mode_nxt = 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        if (slot_free) begin
          if (node_free) begin
            free_map_nxt[scan_node] = 1'b0;
            load                    = 1'b1;
            load_data.granted_node  = scan_node;
            load_data.status        = STAT_GRANT;
            load_data.last          = last_take;
            k_nxt                   = k_r + SIZE_W'(1);
            if (last_take) begin
              state_nxt = ST_IDLE;
            end
          end
          // Advance: round robin moves on to the next group after a take or
          // after the last node of a group; the linear scan wraps to node 0.
          if (rr_mode_r) begin
            if (node_free || rr_j_r == LOCAL_W'(NODES_PER_GROUP - 1)) begin
              rr_j_nxt = '0;
              rr_g_nxt = (rr_g_r == GROUP_W'(GROUPS - 1)) ? '0 : rr_g_r + GROUP_W'(1);
            end else begin
              rr_j_nxt = rr_j_r + LOCAL_W'(1);
            end
          end else begin
            ptr_nxt = (ptr_r == NODE_W'(TOTAL_NODES - 1)) ? '0 : ptr_r + NODE_W'(1);
          end
        end
      end
      ST_REPLY: begin
        if (slot_free) begin
          load      = 1'b1;
          load_data = reply_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      free_map_r <= '1;
    end else begin
      state_r    <= state_nxt;
      free_map_r <= free_map_nxt;
    end
    size_r    <= size_nxt;
    k_r       <= k_nxt;
    rr_mode_r <= rr_mode_nxt;
    ptr_r     <= ptr_nxt;
    rr_g_r    <= rr_g_nxt;
    rr_j_r    <= rr_j_nxt;
    reply_r   <= reply_nxt;
  end

  a_scan_within_size: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (k_r < size_r))
    else $error("scan ran past the job size");

  a_map_held_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COUNT) |=> (free_map_r == $past(free_map_r)))
    else $error("free map changed during counting pass");

  a_done_only_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_res.done |-> (state_r == ST_COUNT))
    else $error("counter finished outside the counting state");

  a_grant_takes_free: assert property (@(posedge clk) disable iff (!rst_n)
    (load && load_data.status == STAT_GRANT) |=> !free_map_r[$past(scan_node)])
    else $error("granted node not marked busy");

endmodule
